@@ rtl/assert_macros.svh @@
// Assertion macros for the parser RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/twfp_pkg.sv @@
// Types and constants for the tagged wire field parser.
// No dependencies; imported by tagged_wire_field_parser_top.
package twfp_pkg;

    localparam logic [28:0] MAX_FIELD_RESET = 29'h1FFF_FFFF;

    // wire types
    localparam logic [2:0] WIRE_VARINT = 3'd0;
    localparam logic [2:0] WIRE_FIX64  = 3'd1;
    localparam logic [2:0] WIRE_LEN    = 3'd2;
    localparam logic [2:0] WIRE_FIX32  = 3'd5;

    typedef enum logic [2:0] {
        PH_TAG     = 3'd0,
        PH_VARINT  = 3'd1,
        PH_FIX64   = 3'd2,
        PH_LEN     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_FIX32   = 3'd5,
        PH_DISCARD = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        KIND_SCALAR  = 2'd0,
        KIND_LEN_HDR = 2'd1,
        KIND_PAYLOAD = 2'd2,
        KIND_ERROR   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_TRUNC     = 3'd1,
        ERR_OVERFLOW  = 3'd2,
        ERR_BAD_FIELD = 3'd3,
        ERR_BAD_WIRE  = 3'd4,
        ERR_SHORT32   = 3'd5,
        ERR_SHORT64   = 3'd6,
        ERR_LEN_LONG  = 3'd7
    } t_err;

    typedef enum logic [1:0] {
        VS_CONT  = 2'd0,
        VS_DONE  = 2'd1,
        VS_OVF   = 2'd2,
        VS_TRUNC = 2'd3
    } t_vstat;

    typedef struct packed {
        logic [7:0]  in_byte;
        logic [31:0] bytes_left;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [28:0] field_number;
        logic [2:0]  wire_kind;
        logic [63:0] field_value;
        logic [2:0]  error_code;
        logic        buffer_end;
    } t_out_word;

endpackage

@@ rtl/tagged_wire_field_parser_top.sv @@
// Tagged wire field parser: decodes protobuf wire format one byte per word.
// Depends on twfp_pkg and assert_macros.svh.
//
// Input channel: i_in_valid / o_in_stall carry i_in_word (one buffer byte
// plus the count of bytes after it; zero marks the buffer's last byte).
// Output channel: o_out_valid / i_out_stall carry o_out_word. A word is
// taken at a rising edge with valid high and stall low.
// Each input word yields zero or one result word: a scalar field, a length
// header, a payload byte, or an error. After an error the rest of the
// buffer is dropped without results.
// A result is registered and appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle while o_in_stall is low; all decoding for a
// byte is one pass of logic between the parser state and the output register.
// Stall: while the output register holds a result and the receiver stalls,
// o_in_stall is high; otherwise a byte is taken every cycle.
// Reset (i_rst_n low, synchronous): parser returns to the tag phase,
// output register empties, max field number returns to 2^29-1.
// i_cfg_we writes max field number; write it only while idle.
module tagged_wire_field_parser_top
    import twfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [28:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word
);

`include "assert_macros.svh"

    t_phase      r_phase, n_phase;
    logic [63:0] r_acc, n_acc;
    logic [3:0]  r_byte_index, n_byte_index;
    logic [28:0] r_held_fn, n_held_fn;
    logic [2:0]  r_held_wk, n_held_wk;
    logic [31:0] r_payload_left, n_payload_left;
    logic [28:0] r_max_fn;
    logic        r_out_valid;
    t_out_word   r_out_word;

    logic        accept;
    logic        last;
    logic [7:0]  b;
    logic [5:0]  v_shamt;
    logic [63:0] v_acc;
    t_vstat      v_stat;
    logic [2:0]  f_idx;
    logic [63:0] f_acc;
    logic [28:0] tag_id;
    logic [2:0]  tag_wire;
    logic        tag_bad;
    logic        len_long;
    logic        fix_done;
    t_err        err;
    logic        res_vld;
    t_out_word   res;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_comb begin
        b    = i_in_word.in_byte;
        last = (i_in_word.bytes_left == 32'd0);

        // varint step: 7 payload bits per byte, tenth byte holds only bit 63
        v_shamt = {2'b00, r_byte_index} * 6'd7;
        if (r_byte_index >= 4'd9) begin
            v_acc  = r_acc | {b[0], 63'd0};
            v_stat = (b > 8'd1) ? VS_OVF : VS_DONE;
        end else begin
            v_acc = r_acc | ({57'd0, b[6:0]} << v_shamt);
            if (!b[7]) begin
                v_stat = VS_DONE;
            end else if (last) begin
                v_stat = VS_TRUNC;
            end else begin
                v_stat = VS_CONT;
            end
        end

        // little-endian fixed value
        f_idx    = r_byte_index[2:0];
        f_acc    = r_acc | ({56'd0, b} << {f_idx, 3'b000});
        fix_done = (r_phase == PH_FIX32) ? (f_idx >= 3'd3) : (f_idx >= 3'd7);

        tag_id   = v_acc[31:3];
        tag_wire = v_acc[2:0];
        tag_bad  = (v_acc[63:32] != 32'd0) || (tag_id == 29'd0) || (tag_id > r_max_fn);
        len_long = (v_acc[63:32] != 32'd0) || (v_acc[31:0] > i_in_word.bytes_left);

        n_phase        = r_phase;
        n_acc          = r_acc;
        n_byte_index   = r_byte_index;
        n_held_fn      = r_held_fn;
        n_held_wk      = r_held_wk;
        n_payload_left = r_payload_left;
        err            = ERR_NONE;
        res_vld        = 1'b0;
        res            = '0;
        res.buffer_end = last;

        unique case (r_phase)
            PH_TAG: begin
                unique case (v_stat)
                    VS_OVF:   err = ERR_OVERFLOW;
                    VS_TRUNC: err = ERR_TRUNC;
                    VS_CONT: begin
                        n_acc        = v_acc;
                        n_byte_index = r_byte_index + 4'd1;
                    end
                    VS_DONE: begin
                        n_acc        = '0;
                        n_byte_index = '0;
                        if (tag_bad) begin
                            err = ERR_BAD_FIELD;
                        end else begin
                            case (tag_wire)
                                WIRE_VARINT: begin
                                    if (last) err = ERR_TRUNC;
                                    else      n_phase = PH_VARINT;
                                end
                                WIRE_LEN: begin
                                    if (last) err = ERR_TRUNC;
                                    else      n_phase = PH_LEN;
                                end
                                WIRE_FIX32: begin
                                    if (i_in_word.bytes_left[31:2] == 30'd0) err = ERR_SHORT32;
                                    else n_phase = PH_FIX32;
                                end
                                WIRE_FIX64: begin
                                    if (i_in_word.bytes_left[31:3] == 29'd0) err = ERR_SHORT64;
                                    else n_phase = PH_FIX64;
                                end
                                default: err = ERR_BAD_WIRE;
                            endcase
                            if (tag_wire == WIRE_VARINT || tag_wire == WIRE_LEN ||
                                tag_wire == WIRE_FIX32 || tag_wire == WIRE_FIX64) begin
                                n_held_fn = tag_id;
                                n_held_wk = tag_wire;
                            end
                        end
                    end
                    default: err = ERR_NONE;
                endcase
            end
            PH_VARINT, PH_LEN: begin
                unique case (v_stat)
                    VS_OVF:   err = ERR_OVERFLOW;
                    VS_TRUNC: err = ERR_TRUNC;
                    VS_CONT: begin
                        n_acc        = v_acc;
                        n_byte_index = r_byte_index + 4'd1;
                    end
                    VS_DONE: begin
                        n_acc        = '0;
                        n_byte_index = '0;
                        if (r_phase == PH_VARINT) begin
                            res_vld          = 1'b1;
                            res.result_kind  = KIND_SCALAR;
                            res.field_number = r_held_fn;
                            res.wire_kind    = WIRE_VARINT;
                            res.field_value  = v_acc;
                            n_phase          = PH_TAG;
                        end else if (len_long) begin
                            err = ERR_LEN_LONG;
                        end else begin
                            res_vld          = 1'b1;
                            res.result_kind  = KIND_LEN_HDR;
                            res.field_number = r_held_fn;
                            res.wire_kind    = WIRE_LEN;
                            res.field_value  = v_acc;
                            if (v_acc[31:0] == 32'd0) begin
                                n_phase = PH_TAG;
                            end else begin
                                n_payload_left = v_acc[31:0];
                                n_phase        = PH_PAYLOAD;
                            end
                        end
                    end
                    default: err = ERR_NONE;
                endcase
            end
            PH_FIX32, PH_FIX64: begin
                if (fix_done) begin
                    res_vld          = 1'b1;
                    res.result_kind  = KIND_SCALAR;
                    res.field_number = r_held_fn;
                    res.wire_kind    = r_held_wk;
                    res.field_value  = f_acc;
                    n_phase          = PH_TAG;
                    n_acc            = '0;
                    n_byte_index     = '0;
                end else if (last) begin
                    err = (r_phase == PH_FIX32) ? ERR_SHORT32 : ERR_SHORT64;
                end else begin
                    n_acc        = f_acc;
                    n_byte_index = {1'b0, f_idx + 3'd1};
                end
            end
            PH_PAYLOAD: begin
                if (last && r_payload_left > 32'd1) begin
                    err = ERR_LEN_LONG;
                end else begin
                    res_vld          = 1'b1;
                    res.result_kind  = KIND_PAYLOAD;
                    res.field_number = r_held_fn;
                    res.wire_kind    = WIRE_LEN;
                    res.field_value  = {56'd0, b};
                    n_payload_left   = r_payload_left - 32'd1;
                    if (r_payload_left == 32'd1) n_phase = PH_TAG;
                end
            end
            default: begin
                // discard until the buffer's last byte
                n_phase = r_phase;
            end
        endcase

        if (err != ERR_NONE) begin
            res_vld          = 1'b1;
            res              = '0;
            res.result_kind  = KIND_ERROR;
            res.error_code   = err;
            res.buffer_end   = last;
            n_phase          = PH_DISCARD;
            n_acc            = '0;
            n_byte_index     = '0;
        end
        if (last) begin
            n_phase        = PH_TAG;
            n_acc          = '0;
            n_byte_index   = '0;
            n_payload_left = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_TAG;
            r_acc          <= '0;
            r_byte_index   <= '0;
            r_held_fn      <= '0;
            r_held_wk      <= '0;
            r_payload_left <= '0;
            r_max_fn       <= MAX_FIELD_RESET;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_fn <= i_cfg_wdata;
            end
            if (accept) begin
                r_phase        <= n_phase;
                r_acc          <= n_acc;
                r_byte_index   <= n_byte_index;
                r_held_fn      <= n_held_fn;
                r_held_wk      <= n_held_wk;
                r_payload_left <= n_payload_left;
                r_out_valid    <= res_vld;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && res_vld) begin
            r_out_word <= res;
        end
    end

    `ASSERT_NOW(a_err_fields_clear, i_clk, i_rst_n,
        r_out_valid && r_out_word.result_kind == KIND_ERROR,
        r_out_word.field_number == 29'd0 && r_out_word.wire_kind == 3'd0 &&
        r_out_word.field_value == 64'd0 && r_out_word.error_code != ERR_NONE,
        "error word carries field data or no code")
    `ASSERT_NOW(a_ok_no_code, i_clk, i_rst_n,
        r_out_valid && r_out_word.result_kind != KIND_ERROR,
        r_out_word.error_code == ERR_NONE,
        "non-error word carries an error code")
    `ASSERT_NEXT(a_last_to_tag, i_clk, i_rst_n,
        accept && i_in_word.bytes_left == 32'd0,
        r_phase == PH_TAG && r_byte_index == 4'd0 && r_acc == 64'd0,
        "parser not back in tag phase after last byte")
    `ASSERT_NOW(a_payload_count, i_clk, i_rst_n,
        r_phase == PH_PAYLOAD,
        r_payload_left != 32'd0,
        "payload phase with nothing left")

endmodule

@@ dv/twfp_field_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the tagged wire field parser: follows the register port and both channels,
// decodes every accepted byte on its own and compares each result word with the oldest one due.
// Depends on twfp_pkg.
module twfp_field_checker
    import twfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [28:0] i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_word    i_in_word,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_word   i_out_word,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_err_words
);

    t_phase      phase    = PH_TAG;
    logic [63:0] acc      = '0;
    logic [3:0]  idx      = '0;
    logic [28:0] held_fn  = '0;
    logic [2:0]  held_wk  = '0;
    logic [31:0] pay_left = '0;
    logic [28:0] max_fn   = MAX_FIELD_RESET;

    t_out_word words_due[$];
    int fails     = 0;
    int checked   = 0;
    int err_words = 0;

    function automatic t_out_word make_word(t_kind kind, logic [28:0] fn, logic [2:0] wk,
                                            logic [63:0] val, t_err err, logic last);
        t_out_word w;
        w.result_kind  = kind;
        w.field_number = fn;
        w.wire_kind    = wk;
        w.field_value  = val;
        w.error_code   = err;
        w.buffer_end   = last;
        return w;
    endfunction

    // append to the tail of the expected-word queue
    task automatic expect_word(input t_out_word w);
        words_due.insert(words_due.size(), w);
    endtask

    task automatic varint_step(input logic [7:0] b, input logic last, output t_vstat st);
        if (idx >= 4'd9) begin
            // tenth byte may only carry bit 63
            if (b > 8'd1) begin
                st = VS_OVF;
            end else begin
                acc[63] = acc[63] | b[0];
                st = VS_DONE;
            end
        end else begin
            acc = acc | (64'(b[6:0]) << (7 * idx));
            if (!b[7]) begin
                st = VS_DONE;
            end else if (last) begin
                st = VS_TRUNC;
            end else begin
                idx = idx + 4'd1;
                st = VS_CONT;
            end
        end
    endtask

    task automatic parse_wire_byte(input t_in_word w);
        logic [7:0]  b;
        logic [31:0] left;
        logic        last;
        t_err        err;
        t_vstat      st;
        logic [63:0] id;
        logic [2:0]  wtype;
        logic [2:0]  last_idx;
        logic [2:0]  fidx;
        b    = w.in_byte;
        left = w.bytes_left;
        last = (left == 32'd0);
        err  = ERR_NONE;
        case (phase)
            PH_TAG: begin
                varint_step(b, last, st);
                if (st == VS_OVF) begin
                    err = ERR_OVERFLOW;
                end else if (st == VS_TRUNC) begin
                    err = ERR_TRUNC;
                end else if (st == VS_DONE) begin
                    id    = acc >> 3;
                    wtype = acc[2:0];
                    acc   = '0;
                    idx   = '0;
                    // field number is checked ahead of the wire type
                    if (id == 64'd0 || id > 64'(max_fn)) begin
                        err = ERR_BAD_FIELD;
                    end else if (wtype != WIRE_VARINT && wtype != WIRE_FIX64 &&
                                 wtype != WIRE_LEN && wtype != WIRE_FIX32) begin
                        err = ERR_BAD_WIRE;
                    end else begin
                        held_fn = id[28:0];
                        held_wk = wtype;
                        if (wtype == WIRE_VARINT || wtype == WIRE_LEN) begin
                            if (last) begin
                                err = ERR_TRUNC;
                            end else if (wtype == WIRE_VARINT) begin
                                phase = PH_VARINT;
                            end else begin
                                phase = PH_LEN;
                            end
                        end else if (wtype == WIRE_FIX32) begin
                            if (left < 32'd4) err = ERR_SHORT32;
                            else phase = PH_FIX32;
                        end else begin
                            if (left < 32'd8) err = ERR_SHORT64;
                            else phase = PH_FIX64;
                        end
                    end
                end
            end
            PH_VARINT, PH_LEN: begin
                varint_step(b, last, st);
                if (st == VS_OVF) begin
                    err = ERR_OVERFLOW;
                end else if (st == VS_TRUNC) begin
                    err = ERR_TRUNC;
                end else if (st == VS_DONE) begin
                    if (phase == PH_VARINT) begin
                        expect_word(make_word(KIND_SCALAR, held_fn, WIRE_VARINT, acc,
                                              ERR_NONE, last));
                        phase = PH_TAG;
                        acc   = '0;
                        idx   = '0;
                    end else if (acc > 64'(left)) begin
                        err = ERR_LEN_LONG;
                    end else begin
                        expect_word(make_word(KIND_LEN_HDR, held_fn, WIRE_LEN, acc,
                                              ERR_NONE, last));
                        if (acc == 64'd0) begin
                            phase = PH_TAG;
                        end else begin
                            pay_left = acc[31:0];
                            phase    = PH_PAYLOAD;
                        end
                        acc = '0;
                        idx = '0;
                    end
                end
            end
            PH_FIX32, PH_FIX64: begin
                last_idx = (phase == PH_FIX32) ? 3'd3 : 3'd7;
                fidx     = idx[2:0];
                acc      = acc | (64'(b) << (8 * fidx));
                if (fidx >= last_idx) begin
                    expect_word(make_word(KIND_SCALAR, held_fn, held_wk, acc,
                                          ERR_NONE, last));
                    phase = PH_TAG;
                    acc   = '0;
                    idx   = '0;
                end else if (last) begin
                    if (phase == PH_FIX32) err = ERR_SHORT32;
                    else err = ERR_SHORT64;
                end else begin
                    idx = {1'b0, fidx} + 4'd1;
                end
            end
            PH_PAYLOAD: begin
                if (last && pay_left > 32'd1) begin
                    err = ERR_LEN_LONG;
                end else begin
                    expect_word(make_word(KIND_PAYLOAD, held_fn, WIRE_LEN, 64'(b),
                                          ERR_NONE, last));
                    pay_left = pay_left - 32'd1;
                    if (pay_left == 32'd0) phase = PH_TAG;
                end
            end
            default: begin
                // dropping the rest of a buffer after an error
            end
        endcase
        if (err != ERR_NONE) begin
            expect_word(make_word(KIND_ERROR, '0, '0, '0, err, last));
            phase = PH_DISCARD;
            acc   = '0;
            idx   = '0;
        end
        if (last) begin
            phase    = PH_TAG;
            acc      = '0;
            idx      = '0;
            pay_left = '0;
        end
    endtask

    task automatic check_field(input string label, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            fails++;
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, label, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_out_word want;
        if (!i_rst_n) begin
            phase    = PH_TAG;
            acc      = '0;
            idx      = '0;
            held_fn  = '0;
            held_wk  = '0;
            pay_left = '0;
            max_fn   = MAX_FIELD_RESET;
            words_due.delete();
        end else begin
            if (i_cfg_we) max_fn = i_cfg_wdata;
            if (i_in_valid && !i_in_stall) parse_wire_byte(i_in_word);
            if (i_out_valid && !i_out_stall) begin
                if (words_due.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result word: expected none, actual 0x%0h",
                             $time, i_out_word);
                end else begin
                    want = words_due.pop_front();
                    checked++;
                    if (want.result_kind == KIND_ERROR) err_words++;
                    check_field("result_kind", want.result_kind, i_out_word.result_kind);
                    check_field("field_number", want.field_number, i_out_word.field_number);
                    check_field("wire_kind", want.wire_kind, i_out_word.wire_kind);
                    check_field("field_value", want.field_value, i_out_word.field_value);
                    check_field("error_code", want.error_code, i_out_word.error_code);
                    check_field("buffer_end", want.buffer_end, i_out_word.buffer_end);
                end
            end
        end
        o_pending    <= words_due.size();
        o_fail_count <= fails;
        o_checked    <= checked;
        o_err_words  <= err_words;
    end

endmodule

@@ dv/tagged_wire_field_parser_top_tb.sv @@
`timescale 1ns / 100ps
// Top of the tagged wire field parser bench: clock, reset, byte-stream stimulus, receiver stall
// pattern and verdict. Depends on twfp_pkg, twfp_field_checker and tagged_wire_field_parser_top.
module tagged_wire_field_parser_top_tb;
    import twfp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_START   = 600;
    localparam int HOLD_LEN     = 200;
    localparam int NUM_PHASES   = 6;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [28:0] cfg_wdata = '0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    t_in_word    in_word   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_word   out_word;

    int fail_count;
    int pending;
    int checked;
    int err_words;

    int          sent_count = 0;
    int          burst_left = 0;
    int          cycles     = 0;
    int          rx_cycle   = 0;
    int          hold_left  = 0;
    logic [28:0] cur_max    = MAX_FIELD_RESET;
    logic [7:0]  msg[$];

    tagged_wire_field_parser_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    twfp_field_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_err_words  (err_words)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: one long hold-off early on, otherwise a rotating stall pattern
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (rx_cycle == HOLD_START) begin
            out_stall <= 1'b1;
            hold_left <= HOLD_LEN;
        end else begin
            case (rx_cycle[7:6])
                2'd0: out_stall <= 1'b0;
                2'd1: out_stall <= ($urandom_range(0, 3) == 0);
                2'd2: out_stall <= ($urandom_range(0, 9) < 7);
                default: out_stall <= (rx_cycle[2:0] < 3'd3);
            endcase
        end
        if (rst_n) rx_cycle <= rx_cycle + 1;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // append one byte to the buffer under construction
    task automatic add_byte(input logic [7:0] v);
        msg.insert(msg.size(), v);
    endtask

    task automatic push_varint(input logic [63:0] v);
        do begin
            add_byte({v > 64'd127, v[6:0]});
            v = v >> 7;
        end while (v != 64'd0);
    endtask

    function automatic logic [63:0] pick_field_number();
        case ($urandom_range(0, 19))
            0: return 64'd0;
            1: return 64'(cur_max) + 64'd1;
            2: return 64'($urandom);
            3, 4: return 64'(cur_max);
            5, 6, 7: return 64'($urandom_range(1, cur_max));
            default: return 64'($urandom_range(1, (cur_max < 29'd15) ? cur_max : 29'd15));
        endcase
    endfunction

    // one field of random content; a few picks are broken on purpose
    task automatic add_field();
        logic [63:0] fn;
        logic [63:0] len;
        logic [2:0]  wtype;
        int          pick;
        fn   = pick_field_number();
        pick = $urandom_range(0, 19);
        if (pick < 5 || pick == 17) wtype = WIRE_VARINT;
        else if (pick < 8) wtype = WIRE_FIX64;
        else if (pick < 13 || pick >= 18) wtype = WIRE_LEN;
        else if (pick < 16) wtype = WIRE_FIX32;
        else begin
            case ($urandom_range(0, 3))
                0: wtype = 3'd3;
                1: wtype = 3'd4;
                2: wtype = 3'd6;
                default: wtype = 3'd7;
            endcase
        end
        push_varint((fn << 3) | 64'(wtype));
        if (pick == 16) begin
            add_byte(8'($urandom));
        end else if (pick == 17) begin
            // ten-byte varint, last byte mostly past bit 63
            repeat (9) add_byte({1'b1, 7'($urandom)});
            add_byte(8'($urandom_range(0, 255)));
        end else if (pick >= 18) begin
            case ($urandom_range(0, 2))
                0: len = 64'($urandom_range(7, 400));
                1: len = 64'($urandom);
                default: len = rand64();
            endcase
            push_varint(len);
            repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
        end else if (wtype == WIRE_VARINT) begin
            push_varint(rand64() >> $urandom_range(0, 64));
        end else if (wtype == WIRE_FIX64) begin
            repeat (8) add_byte(8'($urandom));
        end else if (wtype == WIRE_FIX32) begin
            repeat (4) add_byte(8'($urandom));
        end else begin
            len = 64'($urandom_range(0, 6));
            push_varint(len);
            repeat (int'(len)) add_byte(8'($urandom));
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic [31:0] bl);
        in_valid <= 1'b1;
        in_word  <= '{in_byte: b, bytes_left: bl};
        do @(posedge clk); while (in_stall);
        sent_count++;
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
        end else begin
            burst_left--;
        end
    endtask

    // lying: non-last bytes claim more bytes behind them than the buffer holds
    task automatic send_msg(input bit lying);
        logic [31:0] offset;
        logic [31:0] remaining;
        bit          saturate;
        offset   = lying ? $urandom : 32'd0;
        saturate = lying && ($urandom_range(0, 3) == 0);
        for (int i = 0; i < msg.size(); i++) begin
            remaining = msg.size() - 1 - i;
            if (remaining == 32'd0) send_byte(msg[i], 32'd0);
            else if (saturate) send_byte(msg[i], 32'hFFFF_FFFF);
            else send_byte(msg[i], remaining + offset);
        end
    endtask

    task automatic send_buffer();
        int mode;
        int cut;
        mode = $urandom_range(0, 9);
        msg.delete();
        if (mode == 8) begin
            repeat ($urandom_range(1, 12)) add_byte(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 4)) add_field();
        end
        if (mode == 6 || mode == 9) begin
            cut = $urandom_range(1, msg.size());
            while (msg.size() > cut) void'(msg.pop_back());
        end
        send_msg(mode == 7 || mode == 9);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial begin : stimulus
        int quota;
        int start;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // short directed buffers: varint, payload, zero length, fixed32, fixed64,
        // bad wire type, field zero, varint tag on the buffer's last byte
        msg = '{8'h08, 8'h00, 8'h12, 8'h01, 8'hFF, 8'h1A, 8'h00};
        send_msg(1'b0);
        msg = '{8'h0D, 8'h01, 8'h02, 8'h03, 8'h04};
        send_msg(1'b0);
        msg = '{8'h09, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_msg(1'b0);
        msg = '{8'h0B};
        send_msg(1'b0);
        msg = '{8'h00};
        send_msg(1'b0);
        msg = '{8'h08};
        send_msg(1'b0);

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: quota = 260;
                1: begin quota = 220; cur_max = 29'd1; end
                2: begin quota = 80;  cur_max = 29'd0; end
                3: begin quota = 260; cur_max = MAX_FIELD_RESET; end
                4: begin quota = 260; cur_max = 29'($urandom_range(2, 40)); end
                default: begin
                    quota   = 260;
                    cur_max = 29'($urandom_range(1, MAX_FIELD_RESET));
                end
            endcase
            if (p > 0) begin
                settle();
                cfg_we    <= 1'b1;
                cfg_wdata <= cur_max;
                @(posedge clk);
                cfg_we    <= 1'b0;
            end
            start = sent_count;
            while (sent_count - start < quota) send_buffer();
        end

        settle();
        $display("Sent %0d bytes over %0d field limits; %0d result words checked, %0d errors.",
                 sent_count, NUM_PHASES, checked, err_words);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d results never arrived", fail_count, pending);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
